/* hdl/size_class_buffer_pool_macros.svh */
// ----------------------------------------------------------------------------
// Size class buffer pool assertion macros
// Shared concurrent assertion forms for the buffer pool.
// ----------------------------------------------------------------------------
`ifndef SIZE_CLASS_BUFFER_POOL_MACROS_SVH
`define SIZE_CLASS_BUFFER_POOL_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SCBP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scbp assertion failed");

// Next-cycle implication, checked outside reset.
`define SCBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scbp assertion failed");

`endif

/* hdl/scbp_pkg.sv */
// ----------------------------------------------------------------------------
// Size class buffer pool package
// Types, codes and constants shared by the buffer pool modules.
// ----------------------------------------------------------------------------
package scbp_pkg;

  localparam int ENTRIES_CLASS0 = 64;
  localparam int ENTRIES_CLASS1 = 64;

  localparam int NUM_CLASSES = 2;
  localparam int ENTRY_W     = 6;
  localparam int LINK_W      = ENTRY_W + 1;
  localparam int LINK_DEPTH  = NUM_CLASSES * (2 ** ENTRY_W);
  localparam int ADDR_W      = $clog2(LINK_DEPTH);
  localparam int BYTES_W     = 24;
  localparam int OFFSET_W    = 30;

  localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(2 ** ENTRY_W);

  function automatic logic [LINK_W-1:0] clamp_entries(input int n);
    int c;
    c = n;
    if (c < 1) c = 1;
    if (c > 2 ** ENTRY_W) c = 2 ** ENTRY_W;
    return LINK_W'(c);
  endfunction

  localparam logic [LINK_W-1:0] CLASS0_COUNT = clamp_entries(ENTRIES_CLASS0);
  localparam logic [LINK_W-1:0] CLASS1_COUNT = clamp_entries(ENTRIES_CLASS1);

  localparam logic [BYTES_W-1:0] CLASS0_BYTES_RST = BYTES_W'(2048);
  localparam logic [BYTES_W-1:0] CLASS1_BYTES_RST = BYTES_W'(8192);

  typedef enum logic [0:0] {
    OP_GET     = 1'b0,
    OP_RELEASE = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    ST_GRANTED  = 3'd0,
    ST_HEAP     = 3'd1,
    ST_RETRY    = 3'd2,
    ST_RELEASED = 3'd3,
    ST_HEAP_ACK = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    REG_CLASS0_BYTES = 2'd0,
    REG_CLASS1_BYTES = 2'd1
  } reg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_HOLD
  } state_e;

  typedef struct packed {
    logic accept;
    logic pop_commit;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic get_grant;
    logic out_free;
  } dp_stat_t;

  function automatic logic [LINK_W-1:0] class_count(input logic cls);
    return cls ? CLASS1_COUNT : CLASS0_COUNT;
  endfunction

  function automatic logic [LINK_W-1:0] link_reset_value(input logic [ADDR_W-1:0] addr);
    logic [LINK_W-1:0] nxt;
    nxt = {1'b0, addr[ENTRY_W-1:0]} + LINK_W'(1);
    return (nxt < class_count(addr[ADDR_W-1])) ? nxt : NIL_LINK;
  endfunction

endpackage

/* hdl/scbp_ctrl.sv */
// ----------------------------------------------------------------------------
// Size class buffer pool controller
// Sequences acceptance, free list pop and result hand-off.
// ----------------------------------------------------------------------------
module scbp_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  scbp_pkg::dp_stat_t    stat_i,
  output scbp_pkg::ctrl_cmd_t   cmd_o
);
  import scbp_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = stat_i.get_grant ? S_POP : S_HOLD;
        end
      end
      S_POP: begin
        state_d = stat_i.out_free ? S_IDLE : S_HOLD;
      end
      S_HOLD: begin
        if (stat_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o       = 1'b1;
    cmd_o.accept     = 1'b0;
    cmd_o.pop_commit = 1'b0;
    cmd_o.out_load   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      S_POP: begin
        cmd_o.pop_commit = 1'b1;
        cmd_o.out_load   = stat_i.out_free;
      end
      S_HOLD: begin
        cmd_o.out_load = stat_i.out_free;
      end
      default: in_stall_o = 1'b1;
    endcase
  end

endmodule

/* hdl/scbp_datapath.sv */
// ----------------------------------------------------------------------------
// Size class buffer pool datapath
// Class registers, list heads, link memory, offset multiply and result stages.
// ----------------------------------------------------------------------------
module scbp_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  scbp_pkg::ctrl_cmd_t                cmd_i,
  output scbp_pkg::dp_stat_t                 stat_o,
  input  logic                               cfg_we_i,
  input  logic [1:0]                         cfg_idx_i,
  input  logic [scbp_pkg::BYTES_W-1:0]       cfg_data_i,
  input  logic                               opcode_i,
  input  logic [scbp_pkg::BYTES_W-1:0]       request_bytes_i,
  input  logic                               wait_if_empty_i,
  input  logic [1:0]                         release_class_i,
  input  logic [scbp_pkg::ENTRY_W-1:0]       release_entry_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [2:0]                         status_o,
  output logic                               grant_class_o,
  output logic [scbp_pkg::ENTRY_W-1:0]       grant_entry_o,
  output logic [scbp_pkg::OFFSET_W-1:0]      buffer_offset_o
);
  import scbp_pkg::*;

  logic [NUM_CLASSES-1:0][BYTES_W-1:0] bytes_q;
  logic [NUM_CLASSES-1:0][LINK_W-1:0]  head_q;
  logic [LINK_DEPTH-1:0]               link_vld_q;
  logic [LINK_W-1:0]                   link_mem [LINK_DEPTH];
  logic [LINK_W-1:0]                   rd_link_q;
  logic                                rd_vld_q;

  status_e               stg_status_q, stg_status_d;
  logic                  stg_class_q, stg_class_d;
  logic [ENTRY_W-1:0]    stg_entry_q, stg_entry_d;
  logic [OFFSET_W-1:0]   stg_offset_q, stg_offset_d;

  logic                  out_valid_q;
  status_e               out_status_q;
  logic                  out_class_q;
  logic [ENTRY_W-1:0]    out_entry_q;
  logic [OFFSET_W-1:0]   out_offset_q;

  logic                  fit0, fit1, granted, is_get, do_pop, do_push;
  logic                  rel_cls;
  logic [ENTRY_W-1:0]    head_entry;
  logic [BYTES_W-1:0]    sel_bytes;
  logic [ADDR_W-1:0]     pop_addr, push_addr, commit_addr;
  logic [LINK_W-1:0]     commit_link;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_q[0] <= CLASS0_BYTES_RST;
      bytes_q[1] <= CLASS1_BYTES_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CLASS0_BYTES: bytes_q[0] <= cfg_data_i;
        REG_CLASS1_BYTES: bytes_q[1] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign is_get     = (opcode_i == OP_GET);
  assign fit0       = (request_bytes_i <= bytes_q[0]) && !head_q[0][ENTRY_W];
  assign fit1       = (request_bytes_i <= bytes_q[1]) && !head_q[1][ENTRY_W];
  assign granted    = fit0 || fit1;
  assign head_entry = fit0 ? head_q[0][ENTRY_W-1:0] : head_q[1][ENTRY_W-1:0];
  assign sel_bytes  = fit0 ? bytes_q[0] : bytes_q[1];
  assign pop_addr   = {~fit0, head_entry};

  assign rel_cls   = release_class_i[0];
  assign push_addr = {rel_cls, release_entry_i};
  assign do_pop    = cmd_i.accept && is_get && granted;
  assign do_push   = cmd_i.accept && !is_get && !release_class_i[1]
                     && ({1'b0, release_entry_i} < class_count(rel_cls));

  assign stat_o.get_grant = is_get && granted;
  assign stat_o.out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    stg_status_d = ST_HEAP_ACK;
    stg_class_d  = 1'b0;
    stg_entry_d  = '0;
    stg_offset_d = '0;
    if (is_get) begin
      if (granted) begin
        stg_status_d = ST_GRANTED;
        stg_class_d  = ~fit0;
        stg_entry_d  = head_entry;
        stg_offset_d = OFFSET_W'(head_entry) * OFFSET_W'(sel_bytes);
      end else begin
        stg_status_d = wait_if_empty_i ? ST_RETRY : ST_HEAP;
      end
    end else if (!release_class_i[1]) begin
      stg_status_d = ST_RELEASED;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      stg_status_q <= stg_status_d;
      stg_class_q  <= stg_class_d;
      stg_entry_q  <= stg_entry_d;
      stg_offset_q <= stg_offset_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      link_mem[push_addr] <= head_q[rel_cls];
    end
    if (do_pop) begin
      rd_link_q <= link_mem[pop_addr];
      rd_vld_q  <= link_vld_q[pop_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_vld_q <= '0;
    end else if (do_push) begin
      link_vld_q[push_addr] <= 1'b1;
    end
  end

  assign commit_addr = {stg_class_q, stg_entry_q};
  assign commit_link = rd_vld_q ? rd_link_q : link_reset_value(commit_addr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
    end else if (do_push) begin
      head_q[rel_cls] <= {1'b0, release_entry_i};
    end else if (cmd_i.pop_commit) begin
      head_q[stg_class_q] <= commit_link;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= stg_status_q;
      out_class_q  <= stg_class_q;
      out_entry_q  <= stg_entry_q;
      out_offset_q <= stg_offset_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign grant_class_o   = out_class_q;
  assign grant_entry_o   = out_entry_q;
  assign buffer_offset_o = out_offset_q;

endmodule

/* hdl/size_class_buffer_pool.sv */
// ----------------------------------------------------------------------------
// Size class buffer pool
// Two size classes, each a linked free list, with get and release requests.
// ----------------------------------------------------------------------------
//   channel | direction | handshake             | payload
//   in      | input     | in_valid_i/in_stall_o | opcode, request, wait, release
//   out     | output    | out_valid_o/out_stall_i | status, class, entry, offset
//   cfg     | input     | cfg_we_i              | cfg_idx_i, cfg_data_i
//
// A granted get reads the head entry's link from the link memory in the
// accept cycle and updates the head in the next. The result is held in the
// stage registers, then enters the output register once it is free.
// A new item is taken only once the last result is in the output register.
// Reset restores list heads and marks every link entry as unwritten; there is
// no clearing pass. A stalled output holds the block after its staged result.
// ----------------------------------------------------------------------------
`include "size_class_buffer_pool_macros.svh"

module size_class_buffer_pool (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [1:0]                         cfg_idx_i,
  input  logic [scbp_pkg::BYTES_W-1:0]       cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               opcode_i,
  input  logic [scbp_pkg::BYTES_W-1:0]       request_bytes_i,
  input  logic                               wait_if_empty_i,
  input  logic [1:0]                         release_class_i,
  input  logic [scbp_pkg::ENTRY_W-1:0]       release_entry_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [2:0]                         status_o,
  output logic                               grant_class_o,
  output logic [scbp_pkg::ENTRY_W-1:0]       grant_entry_o,
  output logic [scbp_pkg::OFFSET_W-1:0]      buffer_offset_o
);
  import scbp_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  logic      out_grant;
  logic      out_fields_zero;
  logic      out_entry_ok;

  scbp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  scbp_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .opcode_i        (opcode_i),
    .request_bytes_i (request_bytes_i),
    .wait_if_empty_i (wait_if_empty_i),
    .release_class_i (release_class_i),
    .release_entry_i (release_entry_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .grant_class_o   (grant_class_o),
    .grant_entry_o   (grant_entry_o),
    .buffer_offset_o (buffer_offset_o)
  );

  assign out_grant       = (status_o == ST_GRANTED);
  assign out_fields_zero = (buffer_offset_o == '0) && (grant_entry_o == '0) && !grant_class_o;
  assign out_entry_ok    = ({1'b0, grant_entry_o} < class_count(grant_class_o));

  `SCBP_ASSERT_NEXT(a_busy_after_transfer, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  `SCBP_ASSERT_IMPL(a_no_grant_fields_zero, clk_i, rst_ni, out_valid_o && !out_grant, out_fields_zero)
  `SCBP_ASSERT_IMPL(a_grant_entry_in_range, clk_i, rst_ni, out_valid_o && out_grant, out_entry_ok)

endmodule
